// File: design/pfs_pkg.sv
`default_nettype none
package pfs_pkg;

  typedef logic [2:0] step_t;

  localparam step_t S_CHECK  = 3'd0;
  localparam step_t S_LOAD   = 3'd1;
  localparam step_t S_DIVIDE = 3'd2;
  localparam step_t S_TEST   = 3'd3;
  localparam step_t S_TAKE   = 3'd4;
  localparam step_t S_NEXT   = 3'd5;
  localparam step_t S_FINISH = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_TAKE,
    OP_NEXT_D,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_SQ_GT_M,
    C_REM_NZ,
    C_CNT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control store: trial division with a shared restoring divider.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      S_CHECK:  w = '{op: OP_NOP,      cond: C_SQ_GT_M,  target: S_FINISH};
      S_LOAD:   w = '{op: OP_DIV_LOAD, cond: C_NEVER,    target: S_CHECK};
      S_DIVIDE: w = '{op: OP_DIV_STEP, cond: C_CNT_MORE, target: S_DIVIDE};
      S_TEST:   w = '{op: OP_NOP,      cond: C_REM_NZ,   target: S_NEXT};
      S_TAKE:   w = '{op: OP_TAKE,     cond: C_ALWAYS,   target: S_LOAD};
      S_NEXT:   w = '{op: OP_NEXT_D,   cond: C_ALWAYS,   target: S_CHECK};
      S_FINISH: w = '{op: OP_FINISH,   cond: C_NEVER,    target: S_CHECK};
      default:  w = '{op: OP_FINISH,   cond: C_NEVER,    target: S_CHECK};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: design/prime_factor_sum.sv
// Each trial divisor costs one full division, and each factor found one more with
// the same divisor; the worst case is a prime near 2^WIDTH.
// One item at a time: busy stays high until the result strobe; the next item
// may start in the cycle the strobe is shown. The bit-serial divider sets the rate.
// The receiver cannot stall; done shows for one cycle, the result until the next.
// Reset (rst, synchronous) clears busy and done; an item in progress is dropped.
`default_nettype none
module prime_factor_sum
  import pfs_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] n_value,
  output logic                  done,
  output logic [WIDTH-1:0]      factor_sum,
  output logic                  bad_input
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             running;
  step_t            step;
  step_t            step_next;
  ctrl_t            cw;
  logic             taken;

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] d;
  logic [WIDTH+1:0] dsq;
  logic [WIDTH-1:0] total;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             bad;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;
  logic [WIDTH-1:0] sum_next;

  assign busy = running;
  assign cw   = ucode(step);

  // Jump condition, on register values before this step's update.
  always_comb begin
    unique case (cw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_SQ_GT_M:  taken = dsq > {2'b00, m};
      C_REM_NZ:   taken = rem != '0;
      C_CNT_MORE: taken = cnt != CNT_W'(1);
      default:    taken = 1'b0;
    endcase
    step_next = taken ? cw.target : step + step_t'(1);
  end

  // One restoring division bit per step.
  always_comb begin
    rem_sh   = {rem, quo[WIDTH-1]};
    diff     = rem_sh - {1'b0, d};
    ge       = rem_sh >= {1'b0, d};
    rem_next = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    quo_next = {quo[WIDTH-2:0], ge};
    sum_next = total + ((m > WIDTH'(1)) ? m : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= S_CHECK;
    end else begin
      done <= 1'b0;
      if (!running) begin
        if (start) begin
          running <= 1'b1;
          step    <= S_CHECK;
        end
      end else begin
        step <= step_next;
        if (cw.op == OP_FINISH) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!running) begin
      if (start) begin
        m     <= n_value;
        d     <= WIDTH'(2);
        dsq   <= (WIDTH+2)'(4);
        total <= '0;
        bad   <= n_value == '0;
      end
    end else begin
      unique case (cw.op)
        OP_NOP: begin
        end
        OP_DIV_LOAD: begin
          rem <= '0;
          quo <= m;
          cnt <= CNT_W'(WIDTH);
        end
        OP_DIV_STEP: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
        end
        OP_TAKE: begin
          total <= total + d;
          m     <= quo;
        end
        OP_NEXT_D: begin
          // (d+1)^2 = d^2 + 2d + 1
          dsq <= dsq + {1'b0, d, 1'b1};
          d   <= d + WIDTH'(1);
        end
        OP_FINISH: begin
          factor_sum <= sum_next;
          bad_input  <= bad;
        end
        default: begin
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not start");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_input) |-> factor_sum == '0) else $error("zero input gave nonzero sum");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (busy && step == S_DIVIDE) |-> cnt != '0) else $error("divider count underflow");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int W = 16;
  localparam int RANDOM_ITEMS = 105;
  // worst case: a prime near 2^W, which tries every divisor up to its square root
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [W-1:0] sum;
    logic         flagged;
  } factor_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [W-1:0] n_value = '0;
  logic         busy;
  logic         done;
  logic [W-1:0] factor_sum;
  logic         bad_input;

  logic [W-1:0]   numbers_to_send[$];
  factor_result_t sums_due[$];

  int total_items = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_flagged = 0;
  int fail_count = 0;
  int cycle_count = 0;

  prime_factor_sum #(.WIDTH(W)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .n_value   (n_value),
    .done      (done),
    .factor_sum(factor_sum),
    .bad_input (bad_input)
  );

  always #4 clk = ~clk;

  // Sum of prime factors with multiplicity by trial division.
  function automatic factor_result_t predict_factor_sum(input logic [W-1:0] n);
    factor_result_t r;
    int unsigned rest;
    int unsigned d;
    int unsigned total;
    rest = n;
    d = 2;
    total = 0;
    r.flagged = (n == '0);
    if (n != '0) begin
      while (d * d <= rest) begin
        while (rest % d == 0) begin
          total += d;
          rest /= d;
        end
        d++;
      end
      if (rest > 1) total += rest;
    end
    r.sum = total[W-1:0];
    return r;
  endfunction

  // sender idles rarely, then often, then never
  function automatic int sender_idle_pct();
    if (n_accepted < total_items / 3) return 7;
    else if (n_accepted < (2 * total_items) / 3) return 77;
    else return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        sums_due = {sums_due, predict_factor_sum(n_value)};
        void'(numbers_to_send.pop_front());
        n_accepted++;
      end
      if (numbers_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        start   <= 1'b1;
        n_value <= numbers_to_send[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    factor_result_t want;
    if (!rst && done) begin
      if (sums_due.size() == 0) begin
        $error("unexpected result: factor_sum=%0d bad_input=%0b", factor_sum, bad_input);
        fail_count++;
      end else begin
        want = sums_due.pop_front();
        n_checked++;
        if (want.flagged) n_flagged++;
        if (factor_sum !== want.sum) begin
          $error("factor_sum: expected %0d, got %0d", want.sum, factor_sum);
          fail_count++;
        end
        if (bad_input !== want.flagged) begin
          $error("bad_input: expected %0b, got %0b", want.flagged, bad_input);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sums_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int pick;
    // zero and one, tiny primes, squares of primes at the stop boundary,
    // powers of two, the largest prime and all-ones patterns
    numbers_to_send = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9, 16'd12, 16'd25,
                        16'd49, 16'd97, 16'd255, 16'd256, 16'd32768, 16'd63001,
                        16'd65025, 16'd65498, 16'd65521, 16'd65534, 16'd65535,
                        16'h5555, 16'hAAAA, 16'd0, 16'd0, 16'd1};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) numbers_to_send = {numbers_to_send, W'($urandom_range(0, 1))};
      else if (pick < 40) numbers_to_send = {numbers_to_send, W'($urandom_range(2, 1000))};
      else numbers_to_send = {numbers_to_send, W'($urandom_range(0, 65535))};
    end
    total_items = numbers_to_send.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (numbers_to_send.size() != 0 || sums_due.size() != 0) @(posedge clk);
    // catch any stray strobe after the last result
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("factored %0d numbers, %0d results checked (%0d zero inputs flagged)",
             n_accepted, n_checked, n_flagged);
    $display("sender gaps swept from light to heavy to none over %0d cycles", cycle_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
